@@ hw/rtl/wta_pkg.sv @@
package wta_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned THR_W      = 15;
  localparam int unsigned TIME_W     = 20;
  localparam int unsigned DIV_W      = 16;
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 40;
  localparam int unsigned M_TUSER_W  = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_ENABLE    = 1'b0,
    CFG_FILL_THRESHOLD = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_MOVE   = 2'd0,
    CMD_DRAW   = 2'd1,
    CMD_CORNER = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [SAMPLE_W-1:0] x;
    logic [TIME_W-1:0]        y;
    logic                     pend;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hw/rtl/wta_div.sv @@
module wta_div #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wta_pkg::DIV_W-1:0]   num_i,
  input  logic [wta_pkg::DIV_W-1:0]   den_i,
  output wta_pkg::div_stat_t          stat_o,
  output logic [FRACTION_BITS:0]      quot_o
);
  import wta_pkg::*;

  localparam int unsigned CW = $clog2(FRACTION_BITS + 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(FRACTION_BITS);

  logic                 busy_q;
  logic                 done_q;
  logic [CW-1:0]        cnt_q;
  logic [DIV_W:0]       rem_q;
  logic [DIV_W-1:0]     den_q;
  logic [FRACTION_BITS:0] quot_q;

  logic             take;
  logic [DIV_W:0]   diff;
  logic [DIV_W-1:0] rem_sub;

  // one quotient bit per cycle, restoring form; a zero divisor yields zero
  always_comb begin
    take    = (den_q != '0) && (rem_q >= {1'b0, den_q});
    diff    = rem_q - {1'b0, den_q};
    rem_sub = take ? diff[DIV_W-1:0] : rem_q[DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == LAST_STEP) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= {rem_sub, 1'b0};
      quot_q <= {quot_q[FRACTION_BITS-1:0], take};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

@@ hw/rtl/wiggle_trace_area_fill.sv @@
// variable-area wiggle trace: one trace sample per input transfer, plot
// commands out, one command per output transfer.
// input:  s_axis, tdata = sample, tlast = final sample of the trace.
// output: m_axis, tdata = amplitude_x then time_y, tuser = command then
//   polygon_end, tlast = final command caused by the current sample.
// config: cfg_valid_i/cfg_index_i/cfg_data_i, always ready; index 0 is the
//   fill enable, index 1 the fill threshold. write only while idle.
// each sample gives one to three commands. the sample is taken in the idle
// state, then the commands are sent in order, each held until the receiver
// is ready. a polygon start or end corner between two samples waits in a
// divide state for the crossing time from the serial divider, one quotient
// bit a cycle, before its commands are sent.
// s_axis_tready_o is low from the accepted sample until its last command
// is taken; a stalled receiver simply holds the current command.
// reset clears the trace position, the open polygon and the previous sample,
// turns fill off and sets the threshold to one.
module wiggle_trace_area_fill #(
  parameter int unsigned MAX_SAMPLES   = 4096,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [wta_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,  // [15:0] sample
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [15:0] amplitude_x, [35:16] time_y, [39:36] zero
  output logic [wta_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // [1:0] command, [2] polygon_end
  output logic [wta_pkg::M_TUSER_W-1:0]     m_axis_tuser_o,
  output logic                              m_axis_tlast_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wta_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wta_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import wta_pkg::*;

  localparam int unsigned IW = $clog2(MAX_SAMPLES);
  localparam int unsigned YW = IW + FRACTION_BITS;
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_SAMPLES - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  logic                       fill_q;
  logic [THR_W-1:0]           thr_q;
  logic [IW-1:0]              idx_q, idx_d;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic                       open_q, open_d;
  logic [1:0]                 cnt_q, cnt_d;
  logic [1:0]                 last_q, last_d;
  result_t                    slot_q [3];
  result_t                    slot_d [3];

  logic                       in_xfer;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W-1:0] thr_s;
  logic [YW-1:0]              yfull;
  logic [TIME_W-1:0]          y_i;
  logic                       above, below, trace_end;

  result_t                    plan_slot [3];
  logic [1:0]                 plan_last;
  logic                       plan_open;
  logic [IW-1:0]              plan_idx;
  logic                       need_div;

  logic signed [SAMPLE_W:0]   dif, nm;
  logic [DIV_W-1:0]           div_num, div_den;
  logic                       div_start;
  div_stat_t                  div_stat;
  logic [FRACTION_BITS:0]     div_quot;
  result_t                    cur;

  assign in_xfer     = s_axis_tvalid_i && s_axis_tready_o;
  assign sample      = signed'(s_axis_tdata_i);
  assign thr_s       = signed'({1'b0, thr_q});
  assign yfull       = {idx_q, {FRACTION_BITS{1'b0}}};
  assign y_i         = TIME_W'(yfull);
  assign above       = sample > thr_s;
  assign below       = sample < thr_s;
  assign trace_end   = s_axis_tlast_i || (idx_q >= IDX_LAST);
  assign cfg_ready_o = 1'b1;

  // crossing fraction d/(d-p), made non-negative and clamped to [0,1]
  always_comb begin
    dif = {sample[SAMPLE_W-1], sample} - {prev_q[SAMPLE_W-1], prev_q};
    nm  = {sample[SAMPLE_W-1], sample};
    if (dif < 0) begin
      nm  = -nm;
      dif = -dif;
    end
    if (dif == 0 || nm < 0) begin
      nm = '0;
    end
    if (nm > dif) begin
      nm = dif;
    end
    div_num = nm[DIV_W-1:0];
    div_den = dif[DIV_W-1:0];
  end

  // commands that the sample on the input causes
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      plan_slot[k] = '{cmd: CMD_CORNER, x: thr_s, y: y_i, pend: 1'b0};
    end
    plan_slot[0].cmd = CMD_DRAW;
    plan_slot[0].x   = sample;
    plan_last        = 2'd0;
    plan_open        = open_q;
    plan_idx         = IW'(idx_q + 1'b1);
    need_div         = 1'b0;
    if (idx_q == '0) begin
      plan_slot[0].cmd = CMD_MOVE;
      plan_open        = 1'b0;
      if (fill_q && above) begin
        plan_slot[2].x = sample;
        plan_last      = 2'd2;
        plan_open      = 1'b1;
      end
    end else if (trace_end || !fill_q) begin
      if (open_q) begin
        plan_slot[1].pend = 1'b1;
        plan_last         = 2'd1;
        plan_open         = 1'b0;
      end
      if (trace_end) begin
        plan_idx = '0;
      end
    end else if (above) begin
      if (!open_q) begin
        need_div       = 1'b1;
        plan_slot[2].x = sample;
        plan_last      = 2'd2;
        plan_open      = 1'b1;
      end else begin
        plan_slot[1].x = sample;
        plan_last      = 2'd1;
      end
    end else if (below && open_q) begin
      need_div          = 1'b1;
      plan_slot[1].pend = 1'b1;
      plan_last         = 2'd1;
      plan_open         = 1'b0;
    end
  end

  assign div_start = in_xfer && need_div;

  wta_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    open_d  = open_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    slot_d  = slot_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          slot_d  = plan_slot;
          idx_d   = plan_idx;
          open_d  = plan_open;
          last_d  = plan_last;
          cnt_d   = 2'd0;
          state_d = need_div ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          // slot 0 holds this sample's own time
          slot_d[1].y = slot_q[0].y - TIME_W'(div_quot);
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (m_axis_tready_i) begin
          if (cnt_q == last_q) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= 1'b0;
      thr_q   <= THR_W'(1);
      idx_q   <= '0;
      prev_q  <= '0;
      open_q  <= 1'b0;
      cnt_q   <= 2'd0;
      last_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      open_q  <= open_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      if (in_xfer) begin
        prev_q <= sample;
      end
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_FILL_ENABLE:    fill_q <= cfg_data_i[0];
          CFG_FILL_THRESHOLD: thr_q  <= cfg_data_i;
          default:            fill_q <= fill_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign cur             = slot_q[cnt_q];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_EMIT);
  assign m_axis_tdata_o  = {{(M_TDATA_W - TIME_W - SAMPLE_W){1'b0}}, cur.y, cur.x};
  assign m_axis_tuser_o  = {cur.pend, cur.cmd};
  assign m_axis_tlast_o  = (cnt_q == last_q);

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input taken while a command is pending");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divider finished outside the crossing wait");

  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_tlast_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> s_axis_tready_o)
    else $error("input not ready after the final command");

  a_pend_on_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |-> m_axis_tuser_o[1:0] == CMD_CORNER)
    else $error("polygon end flag on a non-corner command");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_LAST)
    else $error("sample position past the trace limit");

endmodule

@@ sim/tb_wiggle_trace_area_fill.sv @@
`timescale 1ns / 1ps

module tb_wiggle_trace_area_fill;
  import wta_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int TRACE_MAX = 4096;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    result_t res;
    logic    tail;
  } plot_cmd_t;

  // predicts plot commands per accepted sample and matches them in order
  class wiggle_plot_check;
    logic        fill_on;
    int          fill_level;
    int unsigned trace_pos;
    int          prev_sample;
    logic        poly_open;
    plot_cmd_t   pending_cmds[$];
    int          errors;

    function new();
      fill_on     = 1'b0;
      fill_level  = 1;
      trace_pos   = 0;
      prev_sample = 0;
      poly_open   = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FILL_ENABLE:    fill_on = val[0];
        CFG_FILL_THRESHOLD: fill_level = int'(val);
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    function void push(cmd_e c, int x, int unsigned y, logic pend);
      plot_cmd_t e;
      e.res.cmd  = c;
      e.res.x    = 16'(x);
      e.res.y    = 20'(y);
      e.res.pend = pend;
      e.tail     = 1'b0;
      pending_cmds.push_back(e);
    endfunction

    // time of the zero crossing between previous and current sample
    function logic [TIME_W-1:0] cross_time(int unsigned i, int d, int p);
      int num;
      int den;
      longint q;
      num = d;
      den = d - p;
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (den == 0 || num < 0) num = 0;
      if (num > den) num = den;
      q = (den == 0) ? 0 : (longint'(num) << FRAC_BITS) / longint'(den);
      return 20'((longint'(i) << FRAC_BITS) - q);
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] smp, logic tail_in);
      int          d;
      int unsigned i;
      int unsigned y;
      logic        at_end;
      d = int'(smp);
      if (trace_pos == 0) begin
        push(CMD_MOVE, d, 0, 1'b0);
        poly_open = 1'b0;
        if (fill_on && d > fill_level) begin
          push(CMD_CORNER, fill_level, 0, 1'b0);
          push(CMD_CORNER, d, 0, 1'b0);
          poly_open = 1'b1;
        end
        trace_pos = 1;
      end else begin
        i = trace_pos;
        y = i << FRAC_BITS;
        at_end = tail_in || (i >= TRACE_MAX - 1);
        push(CMD_DRAW, d, y, 1'b0);
        if (at_end || !fill_on) begin
          // tie-down at this sample's time
          if (poly_open) begin
            push(CMD_CORNER, fill_level, y, 1'b1);
            poly_open = 1'b0;
          end
          trace_pos = at_end ? 0 : i + 1;
        end else begin
          if (d > fill_level) begin
            if (!poly_open) begin
              push(CMD_CORNER, fill_level, cross_time(i, d, prev_sample), 1'b0);
              poly_open = 1'b1;
            end
            push(CMD_CORNER, d, y, 1'b0);
          end else if (d < fill_level && poly_open) begin
            push(CMD_CORNER, fill_level, cross_time(i, d, prev_sample), 1'b1);
            poly_open = 1'b0;
          end
          trace_pos = i + 1;
        end
      end
      prev_sample = d;
      pending_cmds[pending_cmds.size()-1].tail = 1'b1;
    endfunction

    function void match_command(result_t got, logic got_tail);
      plot_cmd_t want;
      if (pending_cmds.size() == 0) begin
        $display("%0t: command with none expected: cmd=%0d x=%0d y=%0d end=%0b last=%0b",
                 $time, got.cmd, got.x, got.y, got.pend, got_tail);
        errors++;
        return;
      end
      want = pending_cmds.pop_front();
      if (got.cmd !== want.res.cmd || got.x !== want.res.x || got.y !== want.res.y ||
          got.pend !== want.res.pend || got_tail !== want.tail) begin
        $display("%0t: mismatch exp cmd=%0d x=%0d y=%0d end=%0b last=%0b",
                 $time, want.res.cmd, want.res.x, want.res.y, want.res.pend, want.tail);
        $display("%0t:          got cmd=%0d x=%0d y=%0d end=%0b last=%0b",
                 $time, got.cmd, got.x, got.y, got.pend, got_tail);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_e              cfg_index = CFG_FILL_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  wiggle_plot_check sb = new();
  result_t          seen_cmd;
  int               burst_left = 1;
  int               cur_level = 1;
  int unsigned      rx_cycle = 0;
  int unsigned      rx_mode = 0;

  wiggle_trace_area_fill #(
    .MAX_SAMPLES  (TRACE_MAX),
    .FRACTION_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // receiver: ready pattern switches between always, random and one in four
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= (rx_cycle % 4 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      seen_cmd.cmd  = cmd_e'(m_tuser[1:0]);
      seen_cmd.pend = m_tuser[2];
      seen_cmd.x    = m_tdata[15:0];
      seen_cmd.y    = m_tdata[35:16];
      sb.match_command(seen_cmd, m_tlast);
    end
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  // stop sending and wait until every predicted command has been taken
  task automatic settle();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    settle();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_reg(idx, val);
    if (idx == CFG_FILL_THRESHOLD) cur_level = int'(val);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_fill(logic en);
    write_reg(CFG_FILL_ENABLE, {14'($urandom), en});
  endtask

  task automatic send_sample(logic signed [SAMPLE_W-1:0] smp, logic tail);
    int gap;
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= tail;
    do @(posedge clk_i); while (!s_tready);
    sb.take_sample(smp, tail);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // half of the samples near or at the threshold so crossings are frequent
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = cur_level + int'($urandom_range(0, 400)) - 200;
      if (v > 32767) v = 32767;
      return 16'(v);
    end else if (r < 50) begin
      return 16'(cur_level);
    end else if (r < 85) begin
      return 16'($urandom);
    end
    case ($urandom_range(0, 3))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  initial begin
    int  trace_left;
    int  n_items;
    logic tail;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed traces, threshold 100
    set_fill(1'b1);
    write_reg(CFG_FILL_THRESHOLD, 15'd100);
    send_sample(16'sh7fff, 1'b1);   // tlast on the first sample is ignored
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd100, 1'b0);    // equal to threshold
    send_sample(16'sd50, 1'b0);
    send_sample(16'sd200, 1'b0);    // crossing fraction clamps to one
    send_sample(16'sd100, 1'b0);    // equal keeps the polygon open
    send_sample(16'sd300, 1'b0);
    send_sample(16'sd0, 1'b1);      // final sample closes the polygon
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd500, 1'b0);
    set_fill(1'b0);                 // fill off with a polygon open
    send_sample(16'sd600, 1'b0);
    send_sample(16'sd700, 1'b0);
    set_fill(1'b1);
    send_sample(16'sd700, 1'b0);    // flat start, zero denominator
    send_sample(16'sd800, 1'b1);
    write_reg(CFG_FILL_THRESHOLD, 15'd0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
    write_reg(CFG_FILL_THRESHOLD, 15'h7fff);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);

    // random phases; trace state carries across the register changes
    trace_left = 0;
    for (int ph = 0; ph < 10; ph++) begin
      if ($urandom_range(0, 1) == 1) set_fill(ph % 4 != 3);
      case ($urandom_range(0, 5))
        0: write_reg(CFG_FILL_THRESHOLD, 15'd0);
        1: write_reg(CFG_FILL_THRESHOLD, 15'h7fff);
        5: write_reg(CFG_FILL_THRESHOLD, 15'($urandom));
        default: write_reg(CFG_FILL_THRESHOLD, 15'($urandom_range(0, 3000)));
      endcase
      set_fill(ph % 4 != 3);
      n_items = $urandom_range(28, 42);
      for (int k = 0; k < n_items; k++) begin
        if (trace_left <= 0) trace_left = $urandom_range(2, 16);
        tail = (trace_left == 1);
        if ($urandom_range(0, 19) == 0) tail = 1'($urandom_range(0, 1));
        send_sample(pick_sample(), tail);
        trace_left--;
        if ($urandom_range(0, 39) == 0) settle();
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
